// ----- hdl/pale_pkg.sv -----
// shared constants, codes and types of the positional array list engine
`default_nettype none

package pale_pkg;

	// default list capacity
	localparam int CAPACITY_DEF = 32;

	// payload field widths
	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;
	localparam int STAT_W = 3;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MINMAX = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READOUT = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

	// flags from the shared compare unit
	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

endpackage

`default_nettype wire

// ----- hdl/pale_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module pale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/pale_cmp.sv -----
// shared signed compare unit used by search and sort
`default_nettype none

module pale_cmp (
	input  wire logic signed [pale_pkg::VAL_W-1:0] a,
	input  wire logic signed [pale_pkg::VAL_W-1:0] b,
	output pale_pkg::cmp_res_t                     res
);

	always_comb begin
		res.eq = (a == b);
		res.lt = (a < b);
	end

endmodule

`default_nettype wire

// ----- hdl/positional_array_list_engine_core.sv -----
// top level of the positional array list engine: sequencer, list ram and compare unit
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  cmd     | in        | cmd_valid/cmd_stall  | cmd, item_value, position
//  res     | out       | res_valid/res_stall  | status, first_value, second_value,
//          |           |                      | found_index, element_count, last_of_run
//
// one command at a time; cmd_stall is high from the transfer until its last result is loaded.
// append and error cases go from dispatch straight to finish; insert and delete read
// then write each moved entry, search reads then compares each entry looked at, and
// readout reads then outputs each element, all set by the one read port of the list ram
// (registered read) and the one comparator. minmax and readout first insertion-sort the list.
// reset clears count, state and res_valid; list data is undefined, never read before written.
// res_stall holds the result register; the sequencer waits until the register is free.
`default_nettype none

module positional_array_list_engine_core #(
	parameter int CAPACITY = pale_pkg::CAPACITY_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cmd_valid,
	output logic                                      cmd_stall,
	input  wire logic        [pale_pkg::CMD_W-1:0]    cmd,
	input  wire logic signed [pale_pkg::VAL_W-1:0]    item_value,
	input  wire logic        [pale_pkg::POS_W-1:0]    position,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output logic             [pale_pkg::STAT_W-1:0]   status,
	output logic signed      [pale_pkg::VAL_W-1:0]    first_value,
	output logic signed      [pale_pkg::VAL_W-1:0]    second_value,
	output logic             [pale_pkg::IDX_W-1:0]    found_index,
	output logic             [pale_pkg::CNT_W-1:0]    element_count,
	output logic                                      last_of_run
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int MW = (CW > pale_pkg::POS_W) ? CW : pale_pkg::POS_W;
	localparam int XW = MW + 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISPATCH = 5'd1;
	localparam logic [4:0] S_INS_RD = 5'd2;
	localparam logic [4:0] S_INS_WR = 5'd3;
	localparam logic [4:0] S_INS_PUT = 5'd4;
	localparam logic [4:0] S_DEL_RD = 5'd5;
	localparam logic [4:0] S_DEL_WR = 5'd6;
	localparam logic [4:0] S_SRCH_RD = 5'd7;
	localparam logic [4:0] S_SRCH_CHK = 5'd8;
	localparam logic [4:0] S_SORT_KEY_RD = 5'd9;
	localparam logic [4:0] S_SORT_KEY = 5'd10;
	localparam logic [4:0] S_SORT_RD = 5'd11;
	localparam logic [4:0] S_SORT_CMP = 5'd12;
	localparam logic [4:0] S_SORT_PUT = 5'd13;
	localparam logic [4:0] S_SORTED = 5'd14;
	localparam logic [4:0] S_MM_RD0 = 5'd15;
	localparam logic [4:0] S_MM_RD1 = 5'd16;
	localparam logic [4:0] S_MM_GET = 5'd17;
	localparam logic [4:0] S_RO_RD = 5'd18;
	localparam logic [4:0] S_RO_OUT = 5'd19;
	localparam logic [4:0] S_FINISH = 5'd20;

	logic [4:0] state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [pale_pkg::CMD_W-1:0] cmd_q;
	logic [pale_pkg::VAL_W-1:0] val_q;
	logic [pale_pkg::POS_W-1:0] pos_q;
	logic [pale_pkg::VAL_W-1:0] key_q;

	// result being built, moved into the output register in finish
	logic [pale_pkg::STAT_W-1:0] rstat_q;
	logic [pale_pkg::VAL_W-1:0] rfirst_q;
	logic [pale_pkg::VAL_W-1:0] rsecond_q;
	logic [CW-1:0] ridx_q;

	logic out_valid_q;
	logic [pale_pkg::STAT_W-1:0] out_status_q;
	logic [pale_pkg::VAL_W-1:0] out_first_q;
	logic [pale_pkg::VAL_W-1:0] out_second_q;
	logic [pale_pkg::IDX_W-1:0] out_idx_q;
	logic [pale_pkg::CNT_W-1:0] out_count_q;
	logic out_last_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [pale_pkg::VAL_W-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [pale_pkg::VAL_W-1:0] mem_rdata;

	logic [pale_pkg::VAL_W-1:0] cmp_a;
	pale_pkg::cmp_res_t cmp_res;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] i_x;
	logic [XW-1:0] j_x;
	logic [CW-1:0] i_inc;
	logic [CW-1:0] i_dec;
	logic [CW-1:0] j_dec;
	logic [CW-1:0] cnt_dec;
	logic full;
	logic out_free;
	logic out_load;
	logic in_xfer;
	logic out_xfer;

	assign cnt_x = XW'(count_q);
	assign pos_x = XW'(pos_q);
	assign i_x = XW'(i_q);
	assign j_x = XW'(j_q);
	assign i_inc = CW'(i_q + 1'b1);
	assign i_dec = CW'(i_q - 1'b1);
	assign j_dec = CW'(j_q - 1'b1);
	assign cnt_dec = CW'(count_q - 1'b1);
	assign full = (cnt_x >= XW'(CAPACITY));

	assign cmd_stall = (state_q != S_IDLE);
	assign in_xfer = cmd_valid && !cmd_stall;
	assign out_xfer = out_valid_q && !res_stall;
	assign out_free = !out_valid_q || !res_stall;
	assign out_load = out_free && (state_q == S_RO_OUT || state_q == S_FINISH);

	assign res_valid = out_valid_q;
	assign status = out_status_q;
	assign first_value = out_first_q;
	assign second_value = out_second_q;
	assign found_index = out_idx_q;
	assign element_count = out_count_q;
	assign last_of_run = out_last_q;

	// search compares the probe, sort compares the held key
	assign cmp_a = (state_q == S_SRCH_CHK) ? val_q : key_q;

	pale_cmp u_cmp (
		.a   (cmp_a),
		.b   (mem_rdata),
		.res (cmp_res)
	);

	pale_ram #(
		.WIDTH (pale_pkg::VAL_W),
		.DEPTH (CAPACITY)
	) u_list (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = i_q[AW-1:0];
		case (state_q)
			S_DISPATCH: begin
				if (cmd_q == pale_pkg::CMD_APPEND && !full) begin
					mem_we = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = val_q;
				end
			end
			S_INS_RD: mem_raddr = i_dec[AW-1:0];
			S_INS_WR: mem_we = 1'b1;
			S_INS_PUT: begin
				mem_we = 1'b1;
				mem_waddr = pos_x[AW-1:0];
				mem_wdata = val_q;
			end
			S_DEL_RD: mem_raddr = i_inc[AW-1:0];
			S_DEL_WR: mem_we = 1'b1;
			S_SORT_RD: mem_raddr = j_dec[AW-1:0];
			S_SORT_CMP: begin
				mem_we = cmp_res.lt;
				mem_waddr = j_q[AW-1:0];
			end
			S_SORT_PUT: begin
				mem_we = 1'b1;
				mem_waddr = j_q[AW-1:0];
				mem_wdata = key_q;
			end
			S_MM_RD0: mem_raddr = '0;
			S_MM_RD1: mem_raddr = cnt_dec[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cmd_q <= cmd;
						val_q <= item_value;
						pos_q <= position;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					rfirst_q <= '0;
					rsecond_q <= '0;
					ridx_q <= '0;
					case (cmd_q)
						pale_pkg::CMD_APPEND: begin
							state_q <= S_FINISH;
							if (full) begin
								rstat_q <= pale_pkg::STAT_FULL;
							end else begin
								rstat_q <= pale_pkg::STAT_OK;
								count_q <= CW'(count_q + 1'b1);
							end
						end
						pale_pkg::CMD_INSERT: begin
							if (pos_x > cnt_x) begin
								rstat_q <= pale_pkg::STAT_BADPOS;
								state_q <= S_FINISH;
							end else if (full) begin
								rstat_q <= pale_pkg::STAT_FULL;
								state_q <= S_FINISH;
							end else begin
								rstat_q <= pale_pkg::STAT_OK;
								i_q <= count_q;
								state_q <= (cnt_x > pos_x) ? S_INS_RD : S_INS_PUT;
							end
						end
						pale_pkg::CMD_DELETE: begin
							if (count_q == '0) begin
								rstat_q <= pale_pkg::STAT_EMPTY;
								state_q <= S_FINISH;
							end else if (pos_x >= cnt_x) begin
								rstat_q <= pale_pkg::STAT_BADPOS;
								state_q <= S_FINISH;
							end else begin
								rstat_q <= pale_pkg::STAT_OK;
								i_q <= CW'(pos_x);
								if (pos_x + 1'b1 < cnt_x) begin
									state_q <= S_DEL_RD;
								end else begin
									count_q <= cnt_dec;
									state_q <= S_FINISH;
								end
							end
						end
						pale_pkg::CMD_SEARCH: begin
							if (count_q == '0) begin
								rstat_q <= pale_pkg::STAT_EMPTY;
								state_q <= S_FINISH;
							end else begin
								rstat_q <= pale_pkg::STAT_OK;
								i_q <= '0;
								state_q <= S_SRCH_RD;
							end
						end
						pale_pkg::CMD_MINMAX, pale_pkg::CMD_READOUT: begin
							if (count_q == '0) begin
								rstat_q <= pale_pkg::STAT_EMPTY;
								state_q <= S_FINISH;
							end else if (cnt_x > XW'(1)) begin
								rstat_q <= pale_pkg::STAT_OK;
								i_q <= CW'(1);
								state_q <= S_SORT_KEY_RD;
							end else begin
								rstat_q <= pale_pkg::STAT_OK;
								state_q <= S_SORTED;
							end
						end
						default: begin
							rstat_q <= pale_pkg::STAT_OK;
							state_q <= S_FINISH;
						end
					endcase
				end
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					// entry i-1 moved up to i
					i_q <= i_dec;
					state_q <= (i_x > pos_x + 1'b1) ? S_INS_RD : S_INS_PUT;
				end
				S_INS_PUT: begin
					count_q <= CW'(count_q + 1'b1);
					state_q <= S_FINISH;
				end
				S_DEL_RD: state_q <= S_DEL_WR;
				S_DEL_WR: begin
					i_q <= i_inc;
					if (i_x + XW'(2) < cnt_x) begin
						state_q <= S_DEL_RD;
					end else begin
						count_q <= cnt_dec;
						state_q <= S_FINISH;
					end
				end
				S_SRCH_RD: state_q <= S_SRCH_CHK;
				S_SRCH_CHK: begin
					if (cmp_res.eq) begin
						ridx_q <= i_q;
						state_q <= S_FINISH;
					end else if (i_x + 1'b1 < cnt_x) begin
						i_q <= i_inc;
						state_q <= S_SRCH_RD;
					end else begin
						rstat_q <= pale_pkg::STAT_NOTFOUND;
						state_q <= S_FINISH;
					end
				end
				S_SORT_KEY_RD: state_q <= S_SORT_KEY;
				S_SORT_KEY: begin
					key_q <= mem_rdata;
					j_q <= i_q;
					state_q <= S_SORT_RD;
				end
				S_SORT_RD: state_q <= S_SORT_CMP;
				S_SORT_CMP: begin
					// larger neighbor shifts up one place
					if (cmp_res.lt) begin
						j_q <= j_dec;
						state_q <= (j_x == XW'(1)) ? S_SORT_PUT : S_SORT_RD;
					end else begin
						state_q <= S_SORT_PUT;
					end
				end
				S_SORT_PUT: begin
					i_q <= i_inc;
					state_q <= (i_x + 1'b1 < cnt_x) ? S_SORT_KEY_RD : S_SORTED;
				end
				S_SORTED: begin
					i_q <= '0;
					state_q <= (cmd_q == pale_pkg::CMD_MINMAX) ? S_MM_RD0 : S_RO_RD;
				end
				S_MM_RD0: state_q <= S_MM_RD1;
				S_MM_RD1: begin
					rfirst_q <= mem_rdata;
					state_q <= S_MM_GET;
				end
				S_MM_GET: begin
					rsecond_q <= mem_rdata;
					state_q <= S_FINISH;
				end
				S_RO_RD: state_q <= S_RO_OUT;
				S_RO_OUT: begin
					// read address holds at i, so the data waits out a stall
					if (out_free) begin
						out_status_q <= pale_pkg::STAT_OK;
						out_first_q <= mem_rdata;
						out_second_q <= '0;
						out_idx_q <= '0;
						out_count_q <= pale_pkg::CNT_W'(count_q);
						out_last_q <= (i_x + 1'b1 == cnt_x);
						if (i_x + 1'b1 == cnt_x) begin
							state_q <= S_IDLE;
						end else begin
							i_q <= i_inc;
							state_q <= S_RO_RD;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_status_q <= rstat_q;
						out_first_q <= rfirst_q;
						out_second_q <= rsecond_q;
						out_idx_q <= pale_pkg::IDX_W'(ridx_q);
						out_count_q <= pale_pkg::CNT_W'(count_q);
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= XW'(CAPACITY))
		else $error("element count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> (count_q == CW'($past(count_q) + 1'b1) ||
			count_q == CW'($past(count_q) - 1'b1)))
		else $error("element count moved by more than one");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> cmd_stall)
		else $error("command transfer not followed by busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == pale_pkg::STAT_FULL |->
			element_count == pale_pkg::CNT_W'(CAPACITY))
		else $error("list full reported below capacity");
`endif

endmodule

`default_nettype wire
